// File: src/vcps_pkg.sv
// Shared types and constants for the variable-coefficient Poisson stencil.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
package vcps_pkg;

  localparam int unsigned PotW  = 32;
  localparam int unsigned RhoW  = 24;
  localparam int unsigned EntW  = 56;
  localparam int unsigned OpW   = 48;
  localparam int unsigned InvW  = 32;
  localparam int unsigned CoefW = 34;   // face coefficient, up to 2^33
  localparam int unsigned AccW  = 64;

  localparam logic [2:0] CfgSizeX = 3'd0;
  localparam logic [2:0] CfgSizeY = 3'd1;
  localparam logic [2:0] CfgSizeZ = 3'd2;
  localparam logic [2:0] CfgInvDx = 3'd3;
  localparam logic [2:0] CfgInvDy = 3'd4;
  localparam logic [2:0] CfgInvDz = 3'd5;

  // Neighbour fetch slots, in the order the controller reads them.
  typedef enum logic [2:0] {
    SLOT_C  = 3'd0,
    SLOT_XM = 3'd1,
    SLOT_XP = 3'd2,
    SLOT_YM = 3'd3,
    SLOT_YP = 3'd4,
    SLOT_ZM = 3'd5
  } slot_e;

  // Commands from the controller into the datapath.
  typedef struct packed {
    logic       rd_en;     // issue a history read for slot
    slot_e      rd_slot;
    logic       lat_en;    // latch the read data of the previous read
    slot_e      lat_slot;
    logic       wr_en;     // write the current item into history
    logic       calc_go;   // start the arithmetic sequence
  } cmd_t;

  typedef struct packed {
    logic calc_busy;
    logic calc_done;
  } sts_t;

endpackage

// File: src/vcps_div.sv
// Restoring radix-2 divider, one quotient bit a cycle.
// Depends on nothing but its ports.
`timescale 1ns / 1ps
module vcps_div #(
  parameter int unsigned NumW = 64,
  parameter int unsigned DenW = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DenW:0]   trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = '0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q[DenW-1:0], quo_q[NumW-1]};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

// File: src/vcps_datapath.sv
// Datapath: plane history memory, neighbour registers and a sequenced arithmetic
// unit built around one shared divider and one 32x34 multiplier. Uses vcps_pkg.
`timescale 1ns / 1ps
module vcps_datapath #(
  parameter int unsigned AddrW = 13
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  vcps_pkg::cmd_t          cmd_i,
  output vcps_pkg::sts_t          sts_o,
  input  logic [AddrW-1:0]        rd_addr_i,
  input  logic [AddrW-1:0]        wr_addr_i,
  input  logic [vcps_pkg::EntW-1:0] cur_i,
  input  logic [31:0]             inv_dx_i,
  input  logic [31:0]             inv_dy_i,
  input  logic [31:0]             inv_dz_i,
  output logic [vcps_pkg::OpW-1:0]  op_o,
  output logic [vcps_pkg::InvW-1:0] inv_o
);
  localparam int unsigned Depth = 2 ** AddrW;
  localparam logic [63:0] Lim60 = 64'h1000_0000_0000_0000;

  logic [vcps_pkg::EntW-1:0] mem [Depth];
  logic [vcps_pkg::EntW-1:0] rd_q;
  logic [vcps_pkg::EntW-1:0] nb_q [6];
  logic [vcps_pkg::EntW-1:0] zp_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr_i] <= cur_i;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[rd_addr_i];
    end
    if (cmd_i.lat_en) begin
      nb_q[cmd_i.lat_slot] <= rd_q;
    end
    if (cmd_i.calc_go) begin
      zp_q <= cur_i;
    end
  end

  // Arithmetic sequencer: per axis, two face coefficients via the divider, then two fluxes,
  // the axis term and the diagonal term through the multiplier; last, the inverse diagonal via the divider.
  typedef enum logic [8:0] {
    A_IDLE  = 9'b000000001,
    A_DIVP  = 9'b000000010,
    A_DIVM  = 9'b000000100,
    A_FP    = 9'b000001000,
    A_FM    = 9'b000010000,
    A_OP    = 9'b000100000,
    A_DG    = 9'b001000000,
    A_DIVA  = 9'b010000000,
    A_DONE  = 9'b100000000
  } ast_e;

  ast_e        st_q, st_d;
  logic [1:0]  ax_q, ax_d;
  logic        wait_q, wait_d;
  logic [33:0] cp_q, cm_q;
  logic signed [63:0] fp_q, fm_q, op_acc_q;
  logic [63:0] dg_acc_q;
  logic [vcps_pkg::OpW-1:0]  op_q;
  logic [vcps_pkg::InvW-1:0] inv_q;

  logic [vcps_pkg::EntW-1:0] ec, em, ep;
  logic [31:0] inv_sel;
  always_comb begin
    ec = nb_q[vcps_pkg::SLOT_C];
    unique case (ax_q)
      2'd0: begin
        em = nb_q[vcps_pkg::SLOT_XM]; ep = nb_q[vcps_pkg::SLOT_XP]; inv_sel = inv_dx_i;
      end
      2'd1: begin
        em = nb_q[vcps_pkg::SLOT_YM]; ep = nb_q[vcps_pkg::SLOT_YP]; inv_sel = inv_dy_i;
      end
      default: begin
        em = nb_q[vcps_pkg::SLOT_ZM]; ep = zp_q; inv_sel = inv_dz_i;
      end
    endcase
  end

  // Divider operands.
  logic [24:0] s_sel;
  logic [63:0] div_num;
  logic [63:0] div_den;
  logic        div_start, div_done;
  logic [63:0] div_quo;
  always_comb begin
    s_sel = {1'b0, ec[55:32]} + {1'b0, (st_q == A_DIVM) ? em[55:32] : ep[55:32]};
    if (s_sel == '0) s_sel = 25'd1;
    if (st_q == A_DIVA) begin
      div_num = 64'h1_0000_0000 + {1'b0, dg_acc_q[63:1]};
      div_den = dg_acc_q;
    end else begin
      div_num = 64'h2_0000_0000 + 64'(s_sel[24:1]);
      div_den = 64'(s_sel);
    end
  end

  vcps_div #(.NumW(64), .DenW(64)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  // Multiplier: magnitude (up to 64 bits) times a 34-bit factor, done as two
  // 32x34 partial products, the low half first and then the high half.
  logic [63:0] mag_a;
  logic        neg_a;
  logic [33:0] mb;
  logic signed [64:0] pc_s, pe_s, pm_s, sa;
  always_comb begin
    pc_s = $signed({{33{ec[31]}}, ec[31:0]});
    pe_s = $signed({{33{ep[31]}}, ep[31:0]});
    pm_s = $signed({{33{em[31]}}, em[31:0]});
    unique case (st_q)
      A_FP:    begin sa = pe_s - pc_s; mb = cp_q; end
      A_FM:    begin sa = pc_s - pm_s; mb = cm_q; end
      A_OP:    begin sa = 65'(fp_q) - 65'(fm_q); mb = {2'b00, inv_sel}; end
      default: begin sa = $signed({1'b0, 64'(cp_q) + 64'(cm_q)}); mb = {2'b00, inv_sel}; end
    endcase
    neg_a = sa[64];
    mag_a = neg_a ? 64'(-sa) : sa[63:0];
  end

  logic        ph_q;       // multiply phase
  logic [65:0] plo_q;      // low-half partial product
  logic [65:0] phi;
  logic [97:0] prod;
  logic [97:0] prnd;
  logic [63:0] mres;
  always_comb begin
    phi  = 66'(mag_a[63:32]) * 66'(mb);
    prod = {phi, 32'h0} + 98'(plo_q);
    prnd = prod + 98'h8000;
    if (prnd[97:16] > 82'(Lim60)) mres = Lim60;
    else                          mres = prnd[79:16];
  end

  logic signed [63:0] mres_s;
  assign mres_s = neg_a ? -$signed(mres) : $signed(mres);

  logic signed [65:0] op_sum;
  assign op_sum = 66'(op_acc_q) + 66'(mres_s);

  assign div_start = (st_q == A_DIVP || st_q == A_DIVM || st_q == A_DIVA) && !wait_q;

  always_comb begin
    st_d   = st_q;
    ax_d   = ax_q;
    wait_d = wait_q;
    unique case (st_q)
      A_IDLE: if (cmd_i.calc_go) begin st_d = A_DIVP; ax_d = 2'd0; wait_d = 1'b0; end
      A_DIVP, A_DIVM: begin
        if (!wait_q) wait_d = 1'b1;
        else if (div_done) begin
          wait_d = 1'b0;
          st_d = (st_q == A_DIVP) ? A_DIVM : A_FP;
        end
      end
      A_FP: if (ph_q) st_d = A_FM;
      A_FM: if (ph_q) st_d = A_OP;
      A_OP: if (ph_q) st_d = A_DG;
      A_DG: if (ph_q) begin
        if (ax_q == 2'd2) st_d = A_DIVA;
        else begin st_d = A_DIVP; ax_d = ax_q + 2'd1; end
      end
      A_DIVA: begin
        if (dg_acc_q == '0) st_d = A_DONE;
        else if (!wait_q) wait_d = 1'b1;
        else if (div_done) begin wait_d = 1'b0; st_d = A_DONE; end
      end
      A_DONE: st_d = A_IDLE;
      default: st_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= A_IDLE;
      ax_q   <= '0;
      wait_q <= 1'b0;
      ph_q   <= 1'b0;
    end else begin
      st_q   <= st_d;
      ax_q   <= ax_d;
      wait_q <= wait_d;
      ph_q   <= (st_q == A_FP || st_q == A_FM || st_q == A_OP || st_q == A_DG) && !ph_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!ph_q) plo_q <= 66'(mag_a[31:0]) * 66'(mb);
    if (st_q == A_IDLE && cmd_i.calc_go) begin
      op_acc_q <= '0;
      dg_acc_q <= '0;
    end
    if (div_done && st_q == A_DIVP) cp_q <= div_quo[33:0];
    if (div_done && st_q == A_DIVM) cm_q <= div_quo[33:0];
    if (ph_q) begin
      unique case (st_q)
        A_FP: fp_q <= mres_s;
        A_FM: fm_q <= mres_s;
        A_OP: op_acc_q <= op_sum[63:0];
        A_DG: dg_acc_q <= dg_acc_q + mres;
        default: ;
      endcase
    end
    if (st_q == A_DIVA) begin
      if (dg_acc_q == '0) inv_q <= '1;
      else if (div_done) inv_q <= (div_quo[63:32] != '0) ? '1 : div_quo[31:0];
      if ($signed(op_acc_q) > $signed(64'h0000_7FFF_FFFF_FFFF))
        op_q <= 48'h7FFF_FFFF_FFFF;
      else if ($signed(op_acc_q) < $signed(64'hFFFF_8000_0000_0000))
        op_q <= 48'h8000_0000_0000;
      else
        op_q <= op_acc_q[47:0];
    end
  end

  assign sts_o.calc_busy = (st_q != A_IDLE);
  assign sts_o.calc_done = (st_q == A_DONE);
  assign op_o  = op_q;
  assign inv_o = inv_q;
endmodule

// File: src/vcps_ctrl.sv
// Controller: raster position counters, history addressing and fetch sequencing.
// Drives the datapath through vcps_pkg::cmd_t; uses vcps_pkg.
`timescale 1ns / 1ps
module vcps_ctrl #(
  parameter int unsigned XW    = 6,
  parameter int unsigned YW    = 6,
  parameter int unsigned AddrW = 13,
  parameter int unsigned MaxX  = 64,
  parameter int unsigned MaxY  = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  logic [6:0]       size_x_i,
  input  logic [6:0]       size_y_i,
  input  logic [15:0]      size_z_i,
  output vcps_pkg::cmd_t   cmd_o,
  input  vcps_pkg::sts_t   sts_i,
  output logic [AddrW-1:0] rd_addr_o,
  output logic [AddrW-1:0] wr_addr_o,
  output logic [5:0]       cell_x_o,
  output logic [5:0]       cell_y_o,
  output logic [15:0]      cell_z_o,
  output logic             last_o
);
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_CALC  = 4'b0100,
    S_OUT   = 4'b1000
  } st_e;

  st_e         st_q, st_d;
  logic [XW-1:0] px_q, px_d;
  logic [YW-1:0] py_q, py_d;
  logic [15:0] pz_q, pz_d;
  logic [2:0]  fc_q, fc_d;   // fetch slot counter, runs one past the last
  logic        last_q;
  logic [5:0]  ox_q, oy_q;
  logic [15:0] oz_q;

  logic [XW:0] sx;
  logic [YW:0] sy;
  logic [15:0] sz;
  always_comb begin
    sx = (size_x_i < 7'd3) ? (XW+1)'(3) :
         (32'(size_x_i) > MaxX) ? (XW+1)'(MaxX) : (XW+1)'(size_x_i);
    sy = (size_y_i < 7'd3) ? (YW+1)'(3) :
         (32'(size_y_i) > MaxY) ? (YW+1)'(MaxY) : (YW+1)'(size_y_i);
    sz = (size_z_i < 16'd3) ? 16'd3 : size_z_i;
  end

  logic accept, emit, fin_last;
  assign in_ready_o = (st_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign emit = (px_q >= XW'(1)) && ((XW+1)'(px_q) + 2 <= sx) &&
                (py_q >= YW'(1)) && ((YW+1)'(py_q) + 2 <= sy) &&
                (pz_q >= 16'd2) && (17'(pz_q) + 17'd1 <= 17'(sz));
  assign fin_last = ((XW+1)'(px_q) + 2 == sx) && ((YW+1)'(py_q) + 2 == sy) &&
                    (17'(pz_q) + 17'd1 == 17'(sz));

  // Address of (plane, x, y) in the two-plane history.
  function automatic logic [AddrW-1:0] haddr(input logic pl, input logic [XW-1:0] x,
                                             input logic [YW-1:0] y);
    haddr = {pl, y, x};
  endfunction

  always_comb begin
    unique case (fc_q)
      3'd0:    rd_addr_o = haddr(~pz_q[0], px_q, py_q);
      3'd1:    rd_addr_o = haddr(~pz_q[0], px_q - XW'(1), py_q);
      3'd2:    rd_addr_o = haddr(~pz_q[0], px_q + XW'(1), py_q);
      3'd3:    rd_addr_o = haddr(~pz_q[0], px_q, py_q - YW'(1));
      3'd4:    rd_addr_o = haddr(~pz_q[0], px_q, py_q + YW'(1));
      default: rd_addr_o = haddr(pz_q[0], px_q, py_q);
    endcase
  end
  assign wr_addr_o = haddr(pz_q[0], px_q, py_q);

  always_comb begin
    st_d = st_q;
    fc_d = fc_q;
    px_d = px_q;
    py_d = py_q;
    pz_d = pz_q;
    cmd_o = '0;
    cmd_o.rd_slot  = vcps_pkg::slot_e'(fc_q);
    cmd_o.lat_slot = vcps_pkg::slot_e'(fc_q - 3'd1);
    unique case (st_q)
      S_IDLE: if (in_valid_i) begin
        if (emit) begin
          st_d = S_FETCH;
          fc_d = 3'd0;
        end else begin
          cmd_o.wr_en = 1'b1;
          if ((XW+1)'(px_q) + 1 >= sx) begin
            px_d = '0;
            if ((YW+1)'(py_q) + 1 >= sy) begin
              py_d = '0;
              pz_d = (17'(pz_q) + 17'd1 >= 17'(sz)) ? 16'd0 : pz_q + 16'd1;
            end else py_d = py_q + YW'(1);
          end else px_d = px_q + XW'(1);
        end
      end
      S_FETCH: begin
        cmd_o.rd_en  = (fc_q <= 3'd5);
        cmd_o.lat_en = (fc_q != 3'd0);
        fc_d = fc_q + 3'd1;
        if (fc_q == 3'd6) begin
          // Read of the plane below is done; the item can now be overwritten.
          st_d = S_CALC;
          cmd_o.calc_go = 1'b1;
        end
      end
      S_CALC: if (sts_i.calc_done) st_d = S_OUT;
      S_OUT: if (out_ready_i) begin
        st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  // The input transaction of an emitting cell completes at the end of S_FETCH.
  logic take_emit;
  assign take_emit = (st_q == S_FETCH) && (fc_q == 3'd6);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      fc_q <= '0;
      px_q <= '0;
      py_q <= '0;
      pz_q <= '0;
    end else begin
      st_q <= st_d;
      fc_q <= fc_d;
      if (take_emit) begin
        if ((XW+1)'(px_q) + 1 >= sx) begin
          px_q <= '0;
          if ((YW+1)'(py_q) + 1 >= sy) begin
            py_q <= '0;
            pz_q <= (17'(pz_q) + 17'd1 >= 17'(sz)) ? 16'd0 : pz_q + 16'd1;
          end else py_q <= py_q + YW'(1);
        end else px_q <= px_q + XW'(1);
      end else if (accept && !emit) begin
        px_q <= px_d;
        py_q <= py_d;
        pz_q <= pz_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_emit) begin
      ox_q   <= 6'(px_q);
      oy_q   <= 6'(py_q);
      oz_q   <= pz_q - 16'd1;
      last_q <= fin_last;
    end
  end

  assign out_valid_o = (st_q == S_OUT);
  assign cell_x_o = ox_q;
  assign cell_y_o = oy_q;
  assign cell_z_o = oz_q;
  assign last_o   = last_q;
endmodule

// File: src/variable_coeff_poisson_stencil_top.sv
// Variable-coefficient seven-point Poisson stencil with Jacobi inverse diagonal.
// A ghost cell is accepted from idle; an interior cell is accepted only after its neighbour reads,
// and its result then waits on up to seven divisions through the one divider. One cell is computed
// at a time, while one finished result may wait in the output register. Reset (rst_ni,
// asynchronous, active low) clears counters, control and the output register; sizes return
// to 64/64/64 and scales 1.0.
`timescale 1ns / 1ps
module variable_coeff_poisson_stencil_top #(
  parameter int unsigned MAX_ROW_CELLS  = 64,
  parameter int unsigned MAX_PLANE_ROWS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input stream: tdata = potential[31:0], density[55:32].
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [55:0]  s_axis_tdata,
  // Output stream: tdata = operator_value[47:0], inverse_diagonal[79:48],
  // cell_x[85:80], cell_y[91:86], cell_z[107:92], zero fill to 112 bits.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [111:0] m_axis_tdata,
  output logic         m_axis_tlast,
  // Configuration write port.
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);
  localparam int unsigned XW    = $clog2(MAX_ROW_CELLS);
  localparam int unsigned YW    = $clog2(MAX_PLANE_ROWS);
  localparam int unsigned AddrW = 1 + XW + YW;

  // Configuration registers.
  logic [6:0]  size_x_q, size_y_q;
  logic [15:0] size_z_q;
  logic [31:0] inv_dx_q, inv_dy_q, inv_dz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= 7'd64;
      size_y_q <= 7'd64;
      size_z_q <= 16'd64;
      inv_dx_q <= 32'h0001_0000;
      inv_dy_q <= 32'h0001_0000;
      inv_dz_q <= 32'h0001_0000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        vcps_pkg::CfgSizeX: size_x_q <= cfg_data_i[6:0];
        vcps_pkg::CfgSizeY: size_y_q <= cfg_data_i[6:0];
        vcps_pkg::CfgSizeZ: size_z_q <= cfg_data_i[15:0];
        vcps_pkg::CfgInvDx: inv_dx_q <= cfg_data_i;
        vcps_pkg::CfgInvDy: inv_dy_q <= cfg_data_i;
        vcps_pkg::CfgInvDz: inv_dz_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  vcps_pkg::cmd_t cmd;
  vcps_pkg::sts_t sts;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic [5:0]  cell_x, cell_y;
  logic [15:0] cell_z;
  logic [47:0] op_val;
  logic [31:0] inv_val;
  logic        ctl_ready;
  logic        res_valid, res_ready, res_last;
  logic        emit_peek, take_peek;

  // The controller alone sees the input valid; it commands the history writes and
  // holds the transaction until the neighbour reads are finished.
  vcps_ctrl #(
    .XW(XW), .YW(YW), .AddrW(AddrW),
    .MaxX(MAX_ROW_CELLS), .MaxY(MAX_PLANE_ROWS)
  ) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(ctl_ready),
    .out_valid_o(res_valid),
    .out_ready_i(res_ready),
    .size_x_i(size_x_q), .size_y_i(size_y_q), .size_z_i(size_z_q),
    .cmd_o(cmd), .sts_i(sts),
    .rd_addr_o(rd_addr), .wr_addr_o(wr_addr),
    .cell_x_o(cell_x), .cell_y_o(cell_y), .cell_z_o(cell_z),
    .last_o(res_last)
  );

  // Ready is high in idle for a ghost cell, and on the last fetch cycle for
  // an interior cell, which is where that item's history write happens too.
  assign take_peek = cmd.calc_go;
  assign emit_peek = ctl_ready && s_axis_tvalid && !cmd.wr_en;
  assign s_axis_tready = (ctl_ready && !emit_peek) || take_peek;

  vcps_pkg::cmd_t dp_cmd;
  always_comb begin
    dp_cmd = cmd;
    dp_cmd.wr_en = cmd.wr_en || cmd.calc_go;
  end

  vcps_datapath #(.AddrW(AddrW)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i(dp_cmd), .sts_o(sts),
    .rd_addr_i(rd_addr), .wr_addr_i(wr_addr),
    .cur_i(s_axis_tdata),
    .inv_dx_i(inv_dx_q), .inv_dy_i(inv_dy_q), .inv_dz_i(inv_dz_q),
    .op_o(op_val), .inv_o(inv_val)
  );

  // The output register takes a finished result off the controller, so the
  // next cells are taken in while that result waits for the receiver. It
  // reloads in the same cycle that its transaction completes.
  logic         ob_valid_q, ob_valid_d;
  logic [111:0] ob_data_q, ob_data_d;
  logic         ob_last_q, ob_last_d;

  assign res_ready = !ob_valid_q || m_axis_tready;

  always_comb begin
    ob_valid_d = ob_valid_q;
    ob_data_d  = ob_data_q;
    ob_last_d  = ob_last_q;
    if (res_valid && res_ready) begin
      ob_valid_d = 1'b1;
      ob_data_d  = {4'b0000, cell_z, cell_y, cell_x, inv_val, op_val};
      ob_last_d  = res_last;
    end else if (m_axis_tready) begin
      ob_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_valid_q <= 1'b0;
      ob_data_q  <= '0;
      ob_last_q  <= 1'b0;
    end else begin
      ob_valid_q <= ob_valid_d;
      ob_data_q  <= ob_data_d;
      ob_last_q  <= ob_last_d;
    end
  end

  assign m_axis_tvalid = ob_valid_q;
  assign m_axis_tdata  = ob_data_q;
  assign m_axis_tlast  = ob_last_q;
endmodule

// File: src/vcps_checker.sv
// Port-level checker for the stencil top level, attached by bind below.
// Uses only the top level's ports.
`timescale 1ns / 1ps
module vcps_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [111:0] m_axis_tdata,
  input logic         m_axis_tlast
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_hs_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({s_axis_tready, m_axis_tvalid}))
    else $error("handshake signal unknown");

  a_x_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[85:80] != 6'd0 && m_axis_tdata[91:86] != 6'd0)
    else $error("ghost cell emitted");

  a_z_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[107:92] != 16'd0)
    else $error("ghost plane emitted");
endmodule

bind variable_coeff_poisson_stencil_top vcps_checker u_vcps_checker (
  .clk_i, .rst_ni, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
);
